// ===== hw/rtl/ngti_pkg.sv =====
`default_nettype none
package ngti_pkg;
   localparam int MaxDim = 64;
   localparam int CoordBits = 32;
   localparam int DensBits = 24;
   localparam int DimBits = 6;
   localparam int BIdxBits = 7;
   localparam int FracBits = 16;
   localparam int SumBits = CoordBits + 2;

   typedef enum logic [2:0] {
      REQ_XB = 3'd0, REQ_YB = 3'd1, REQ_ZB = 3'd2, REQ_DENS = 3'd3, REQ_QUERY = 3'd4
   } req_type_type;

   localparam logic [1:0] CSR_VX = 2'd0;
   localparam logic [1:0] CSR_VY = 2'd1;
   localparam logic [1:0] CSR_VZ = 2'd2;

   typedef enum logic [4:0] {
      ST_IDLE, ST_RANGE_LO, ST_RANGE_HI, ST_SEARCH, ST_CTR_A, ST_CTR_B,
      ST_LO0, ST_LO1, ST_LO2, ST_DIV, ST_NEXT_AXIS,
      ST_RD, ST_RD_WAIT, ST_MUL_A, ST_MUL_B, ST_LERP, ST_DONE, ST_OUT
   } state_type;

   // Lerp request between the sequencer and the blend unit.
   typedef struct packed {
      logic start;
      logic [DensBits-1:0] a;
      logic [DensBits-1:0] b;
      logic [FracBits:0] t;
   } lerp_req_type;

   function automatic logic [BIdxBits-1:0] used_count(input logic [6:0] r);
      if (r < 7'd3) return BIdxBits'(3);
      if (r > 7'(MaxDim)) return BIdxBits'(MaxDim);
      return r;
   endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/nonuniform_grid_trilinear_interp_top.sv =====
`default_nettype none
// Trilinear interpolation over a rectilinear grid with per-axis boundary tables.
// Boundary and density writes, and transfers of an unknown kind, are accepted one
// per cycle and give no result. A query holds the block: per axis it checks the
// range, examines up to voxels-1 boundaries in turn in the search, picks the
// neighbour voxels, forms the ratio, running the 16-step restoring divider when
// the ratio lies strictly between 0 and 1, and moves on. It then makes the eight
// density reads from the single-port store and the seven shared lerps. A point
// found outside ends the query early, and the block accepts no transfer while a
// query runs or its result waits.
module nonuniform_grid_trilinear_interp_top (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic req_tready,
   // req_type[2:0], bound_index[9:3], bound_value[41:10], voxel_x[47:42],
   // voxel_y[53:48], voxel_z[59:54], density_value[83:60], query_x[115:84],
   // query_y[147:116], query_z[179:148]
   input  wire logic [183:0] req_tdata,
   output logic rsp_tvalid,
   input  wire logic rsp_tready,
   // interp_density[23:0], in_range[24]
   output logic [31:0] rsp_tdata,
   input  wire logic csr_we,
   input  wire logic [1:0] csr_index,
   input  wire logic [6:0] csr_wdata
);
   localparam int CB = ngti_pkg::CoordBits;
   localparam int SB = ngti_pkg::SumBits;
   localparam int DB = ngti_pkg::DensBits;
   localparam int DM = ngti_pkg::DimBits;
   localparam int BI = ngti_pkg::BIdxBits;
   localparam int FB = ngti_pkg::FracBits;

   logic [2:0] f_type;
   logic [BI-1:0] f_bidx;
   logic [CB-1:0] f_bval;
   logic [DM-1:0] f_vx, f_vy, f_vz;
   logic [DB-1:0] f_dens;
   logic [CB-1:0] f_q [3];
   assign f_type = req_tdata[2:0];
   assign f_bidx = req_tdata[9:3];
   assign f_bval = req_tdata[41:10];
   assign f_vx = req_tdata[47:42];
   assign f_vy = req_tdata[53:48];
   assign f_vz = req_tdata[59:54];
   assign f_dens = req_tdata[83:60];
   assign f_q[0] = req_tdata[115:84];
   assign f_q[1] = req_tdata[147:116];
   assign f_q[2] = req_tdata[179:148];

   logic [6:0] vox_ff [3];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < 3; a++) vox_ff[a] <= 7'(ngti_pkg::MaxDim);
      end else if (csr_we) begin
         case (csr_index)
            ngti_pkg::CSR_VX: vox_ff[0] <= csr_wdata;
            ngti_pkg::CSR_VY: vox_ff[1] <= csr_wdata;
            ngti_pkg::CSR_VZ: vox_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Boundary memories, one per axis, and the density store.
   logic [CB-1:0] xb_mem [ngti_pkg::MaxDim+1];
   logic [CB-1:0] yb_mem [ngti_pkg::MaxDim+1];
   logic [CB-1:0] zb_mem [ngti_pkg::MaxDim+1];
   logic [DB-1:0] d_mem [ngti_pkg::MaxDim*ngti_pkg::MaxDim*ngti_pkg::MaxDim];

   ngti_pkg::state_type st_ff, st_in;
   logic [1:0] ax_ff, ax_in;
   logic [CB-1:0] p_ff [3];
   logic [BI-1:0] k_ff, k_in, i_ff, i_in;
   logic [BI-1:0] n_ff, n_in;
   logic [BI-1:0] ra;
   logic [CB-1:0] rd_ff, b0_ff, b0_in, b1_ff, b1_in;
   logic [DM-1:0] lo_ff [3];
   logic [DM-1:0] lo_in;
   logic lo_we;
   logic [FB:0] t_ff [3];
   logic [FB:0] t_new;
   logic t_we;
   logic [SB-1:0] num_ff, num_in, span_ff, span_in, s01_ff, s01_in;
   logic [2:0] c_ff, c_in;
   logic [DB-1:0] dv_ff [8];
   logic [DB-1:0] dr_ff;
   logic dv_we;
   logic [2:0] l_ff, l_in;
   logic in_range_ff, in_range_in;
   logic [DB-1:0] res_ff, res_in;
   logic div_start;
   logic [FB-1:0] div_q;
   logic div_done;
   ngti_pkg::lerp_req_type lreq;
   logic [DB-1:0] lres;
   logic ldone;
   logic [DB-1:0] blend_ff [7];
   logic blend_we;

   logic [SB-1:0] p2;
   always_comb p2 = {{(SB-CB-1){p_ff[ax_ff][CB-1]}}, p_ff[ax_ff], 1'b0};

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         if (f_type == ngti_pkg::REQ_XB && f_bidx <= BI'(ngti_pkg::MaxDim))
            xb_mem[f_bidx] <= f_bval;
         if (f_type == ngti_pkg::REQ_YB && f_bidx <= BI'(ngti_pkg::MaxDim))
            yb_mem[f_bidx] <= f_bval;
         if (f_type == ngti_pkg::REQ_ZB && f_bidx <= BI'(ngti_pkg::MaxDim))
            zb_mem[f_bidx] <= f_bval;
         if (f_type == ngti_pkg::REQ_DENS) d_mem[{f_vx, f_vy, f_vz}] <= f_dens;
      end
      case (ax_in)
         2'd0: rd_ff <= xb_mem[ra];
         2'd1: rd_ff <= yb_mem[ra];
         default: rd_ff <= zb_mem[ra];
      endcase
   end

   logic [DM-1:0] dx, dy, dz;
   assign dx = lo_ff[0] + DM'(c_ff[0]);
   assign dy = lo_ff[1] + DM'(c_ff[1]);
   assign dz = lo_ff[2] + DM'(c_ff[2]);
   always_ff @(posedge clock) dr_ff <= d_mem[{dx, dy, dz}];

   ngti_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(num_ff), .den(span_ff),
      .quot(div_q), .done(div_done)
   );
   ngti_lerp u_lerp (
      .clock(clock), .reset(reset), .req(lreq), .result(lres), .done(ldone)
   );

   logic signed [SB-1:0] rd_s;
   assign rd_s = SB'(signed'(rd_ff));
   logic signed [SB-1:0] pc_s;
   assign pc_s = SB'(signed'(p_ff[ax_ff]));

   always_comb begin
      st_in = st_ff;
      ax_in = ax_ff;
      k_in = k_ff;
      i_in = i_ff;
      n_in = n_ff;
      ra = k_ff;
      b0_in = b0_ff;
      b1_in = b1_ff;
      lo_in = lo_ff[ax_ff];
      lo_we = 1'b0;
      t_new = '0;
      t_we = 1'b0;
      num_in = num_ff;
      span_in = span_ff;
      s01_in = s01_ff;
      c_in = c_ff;
      dv_we = 1'b0;
      l_in = l_ff;
      in_range_in = in_range_ff;
      res_in = res_ff;
      div_start = 1'b0;
      lreq = '0;
      blend_we = 1'b0;
      req_tready = 1'b0;
      case (st_ff)
         ngti_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            ax_in = 2'd0;
            ra = BI'(1);
            if (req_tvalid && f_type == ngti_pkg::REQ_QUERY) begin
               n_in = ngti_pkg::used_count(vox_ff[0]);
               st_in = ngti_pkg::ST_RANGE_LO;
            end
         end
         ngti_pkg::ST_RANGE_LO: begin
            ra = n_ff - BI'(1);
            if (pc_s <= rd_s) begin
               in_range_in = 1'b0;
               res_in = '0;
               st_in = ngti_pkg::ST_OUT;
            end else st_in = ngti_pkg::ST_RANGE_HI;
         end
         ngti_pkg::ST_RANGE_HI: begin
            k_in = BI'(1);
            ra = BI'(1);
            if (pc_s >= rd_s) begin
               in_range_in = 1'b0;
               res_in = '0;
               st_in = ngti_pkg::ST_OUT;
            end else st_in = ngti_pkg::ST_SEARCH;
         end
         ngti_pkg::ST_SEARCH: begin
            // rd_ff holds b[k]; k is voxel index + 1.
            ra = k_ff + BI'(1);
            k_in = k_ff + BI'(1);
            if (pc_s <= rd_s || k_ff == n_ff) begin
               i_in = k_ff - BI'(1);
               if (k_ff == n_ff) i_in = n_ff - BI'(2);
               if (k_ff - BI'(1) < BI'(1)) i_in = BI'(1);
               if (k_ff - BI'(1) > n_ff - BI'(2)) i_in = n_ff - BI'(2);
               st_in = ngti_pkg::ST_CTR_A;
            end
         end
         ngti_pkg::ST_CTR_A: begin
            ra = i_ff;
            st_in = ngti_pkg::ST_CTR_B;
         end
         ngti_pkg::ST_CTR_B: begin
            ra = i_ff + BI'(1);
            b0_in = rd_ff;
            st_in = ngti_pkg::ST_LO0;
         end
         ngti_pkg::ST_LO0: begin
            // rd_ff = b[i+1], b0 = b[i].
            if ($signed(p2) < $signed(SB'(signed'(b0_ff)) + rd_s)) begin
               lo_in = DM'(i_ff - BI'(1));
               ra = i_ff - BI'(1);
            end else begin
               lo_in = DM'(i_ff);
               ra = i_ff;
            end
            lo_we = 1'b1;
            st_in = ngti_pkg::ST_LO1;
         end
         ngti_pkg::ST_LO1: begin
            ra = BI'(lo_ff[ax_ff]) + BI'(1);
            b0_in = rd_ff;
            st_in = ngti_pkg::ST_LO2;
         end
         ngti_pkg::ST_LO2: begin
            ra = BI'(lo_ff[ax_ff]) + BI'(2);
            b1_in = rd_ff;
            st_in = ngti_pkg::ST_DIV;
            k_in = '0;
         end
         ngti_pkg::ST_DIV: begin
            // b0 = b[lo], b1 = b[lo+1], rd_ff = b[lo+2] on the first step.
            if (k_ff == '0) begin
               s01_in = SB'(signed'(b0_ff)) + SB'(signed'(b1_ff));
               span_in = rd_s - SB'(signed'(b0_ff));
               k_in = BI'(1);
            end else if (k_ff == BI'(1)) begin
               num_in = p2 - s01_ff;
               k_in = BI'(2);
            end else if (k_ff == BI'(2)) begin
               if ($signed(num_ff) <= 0) begin
                  t_new = '0;
                  t_we = 1'b1;
                  st_in = ngti_pkg::ST_NEXT_AXIS;
               end else if ($signed(num_ff) >= $signed(span_ff)) begin
                  t_new = (FB+1)'(1) << FB;
                  t_we = 1'b1;
                  st_in = ngti_pkg::ST_NEXT_AXIS;
               end else begin
                  div_start = 1'b1;
                  k_in = BI'(3);
               end
            end else if (div_done) begin
               t_new = {1'b0, div_q};
               t_we = 1'b1;
               st_in = ngti_pkg::ST_NEXT_AXIS;
            end
         end
         ngti_pkg::ST_NEXT_AXIS: begin
            if (ax_ff == 2'd2) begin
               c_in = '0;
               st_in = ngti_pkg::ST_RD;
            end else begin
               ax_in = ax_ff + 2'd1;
               n_in = ngti_pkg::used_count(vox_ff[ax_ff + 2'd1]);
               ra = BI'(1);
               st_in = ngti_pkg::ST_RANGE_LO;
            end
         end
         ngti_pkg::ST_RD: st_in = ngti_pkg::ST_RD_WAIT;
         ngti_pkg::ST_RD_WAIT: begin
            dv_we = 1'b1;
            c_in = c_ff + 3'd1;
            if (c_ff == 3'd7) begin
               l_in = '0;
               st_in = ngti_pkg::ST_MUL_A;
            end else st_in = ngti_pkg::ST_RD;
         end
         ngti_pkg::ST_MUL_A: begin
            lreq.start = 1'b1;
            case (l_ff)
               3'd0: begin lreq.a = dv_ff[0]; lreq.b = dv_ff[1]; lreq.t = t_ff[0]; end
               3'd1: begin lreq.a = dv_ff[2]; lreq.b = dv_ff[3]; lreq.t = t_ff[0]; end
               3'd2: begin lreq.a = dv_ff[4]; lreq.b = dv_ff[5]; lreq.t = t_ff[0]; end
               3'd3: begin lreq.a = dv_ff[6]; lreq.b = dv_ff[7]; lreq.t = t_ff[0]; end
               3'd4: begin lreq.a = blend_ff[0]; lreq.b = blend_ff[1]; lreq.t = t_ff[1]; end
               3'd5: begin lreq.a = blend_ff[2]; lreq.b = blend_ff[3]; lreq.t = t_ff[1]; end
               default: begin
                  lreq.a = blend_ff[4]; lreq.b = blend_ff[5]; lreq.t = t_ff[2];
               end
            endcase
            st_in = ngti_pkg::ST_MUL_B;
         end
         ngti_pkg::ST_MUL_B: st_in = ngti_pkg::ST_LERP;
         ngti_pkg::ST_LERP: begin
            if (ldone) begin
               blend_we = 1'b1;
               l_in = l_ff + 3'd1;
               if (l_ff == 3'd6) begin
                  res_in = lres;
                  in_range_in = 1'b1;
                  st_in = ngti_pkg::ST_OUT;
               end else st_in = ngti_pkg::ST_MUL_A;
            end
         end
         ngti_pkg::ST_OUT: begin
            if (rsp_tready) st_in = ngti_pkg::ST_IDLE;
         end
         default: st_in = ngti_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ngti_pkg::ST_IDLE;
         ax_ff <= '0;
      end else begin
         st_ff <= st_in;
         ax_ff <= ax_in;
      end
      if (req_tvalid && req_tready) begin
         p_ff[0] <= f_q[0];
         p_ff[1] <= f_q[1];
         p_ff[2] <= f_q[2];
      end
      k_ff <= k_in;
      i_ff <= i_in;
      n_ff <= n_in;
      b0_ff <= b0_in;
      b1_ff <= b1_in;
      num_ff <= num_in;
      span_ff <= span_in;
      s01_ff <= s01_in;
      c_ff <= c_in;
      l_ff <= l_in;
      in_range_ff <= in_range_in;
      res_ff <= res_in;
      if (lo_we) lo_ff[ax_ff] <= lo_in;
      if (t_we) t_ff[ax_ff] <= t_new;
      if (dv_we) dv_ff[{c_ff[2], c_ff[1], c_ff[0]}] <= dr_ff;
      if (blend_we && l_ff != 3'd6) blend_ff[l_ff] <= lres;
   end

   // dv_ff ordering: index bit0 = x offset, bit1 = y, bit2 = z.
   assign rsp_tvalid = (st_ff == ngti_pkg::ST_OUT);
   assign rsp_tdata = {7'd0, in_range_ff, res_ff};

`ifndef ASSERT_OFF
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (st_ff != ngti_pkg::ST_IDLE) |-> !req_tready) else $error("ready while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("result changed while stalled");
   a_out_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !in_range_ff) |-> (res_ff == '0)) else $error("outside nonzero");
`endif
endmodule
`default_nettype wire

// ===== hw/rtl/ngti_lerp.sv =====
`default_nettype none
module ngti_lerp (
   input  wire logic clock,
   input  wire logic reset,
   input  wire ngti_pkg::lerp_req_type req,
   output logic [ngti_pkg::DensBits-1:0] result,
   output logic done
);
   localparam int PW = ngti_pkg::DensBits + ngti_pkg::FracBits + 2;
   logic [1:0] step_ff, step_in;
   logic [PW-1:0] acc_ff, acc_in;
   logic [ngti_pkg::DensBits-1:0] b_ff, b_in;
   logic [ngti_pkg::FracBits:0] t_ff, t_in;

   always_comb begin
      step_in = step_ff;
      acc_in = acc_ff;
      b_in = b_ff;
      t_in = t_ff;
      case (step_ff)
         2'd0: begin
            if (req.start) begin
               acc_in = PW'(req.a) * PW'(17'h10000 - req.t);
               b_in = req.b;
               t_in = req.t;
               step_in = 2'd1;
            end
         end
         2'd1: begin
            acc_in = acc_ff + PW'(b_ff) * PW'(t_ff) + PW'(32768);
            step_in = 2'd2;
         end
         default: step_in = 2'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 2'd0;
      end else begin
         step_ff <= step_in;
      end
      acc_ff <= acc_in;
      b_ff <= b_in;
      t_ff <= t_in;
   end

   assign result = acc_ff[ngti_pkg::FracBits +: ngti_pkg::DensBits];
   assign done = (step_ff == 2'd2);
endmodule
`default_nettype wire

// ===== hw/rtl/ngti_div.sv =====
`default_nettype none
module ngti_div (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic [ngti_pkg::SumBits-1:0] num,
   input  wire logic [ngti_pkg::SumBits-1:0] den,
   output logic [ngti_pkg::FracBits-1:0] quot,
   output logic done
);
   localparam int RW = ngti_pkg::SumBits + 1;
   logic [RW-1:0] rem_ff, rem_in, sh;
   logic [ngti_pkg::SumBits-1:0] den_ff, den_in;
   logic [ngti_pkg::FracBits-1:0] q_ff, q_in;
   logic [4:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      rem_in = rem_ff;
      den_in = den_ff;
      q_in = q_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      sh = rem_ff << 1;
      if (start) begin
         rem_in = RW'(num);
         den_in = den;
         q_in = '0;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (sh >= RW'(den_ff)) begin
            rem_in = sh - RW'(den_ff);
            q_in = {q_ff[ngti_pkg::FracBits-2:0], 1'b1};
         end else begin
            rem_in = sh;
            q_in = {q_ff[ngti_pkg::FracBits-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(ngti_pkg::FracBits - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff <= q_in;
      cnt_ff <= cnt_in;
   end

   assign quot = q_ff;
   assign done = done_ff;
endmodule
`default_nettype wire

// ===== test/nonuniform_grid_trilinear_interp_checker.sv =====
`timescale 1ns / 1ps
module nonuniform_grid_trilinear_interp_checker
   import ngti_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   input  wire logic req_tready,
   input  wire logic [183:0] req_tdata,
   input  wire logic rsp_tvalid,
   input  wire logic rsp_tready,
   input  wire logic [31:0] rsp_tdata,
   input  wire logic csr_we,
   input  wire logic [1:0] csr_index,
   input  wire logic [6:0] csr_wdata,
   output int mismatches,
   output int pending_results,
   output int inside_results
);
   typedef struct packed {
      logic in_range;
      logic [DensBits-1:0] density;
   } sample_type;

   longint edge_tab[3][MaxDim+1];
   logic [DensBits-1:0] voxel_dens[MaxDim*MaxDim*MaxDim];
   logic [6:0] voxel_regs[3];
   sample_type expected_q[$];

   function automatic int clamp_count(logic [6:0] r);
      if (r < 3) return 3;
      if (r > MaxDim) return MaxDim;
      return r;
   endfunction

   function automatic bit find_cell(int ax, int n, longint p, output int lo,
                                    output longint unsigned t);
      int i;
      longint num, span;
      i = n - 2;
      lo = 0;
      t = 0;
      if (p <= edge_tab[ax][1] || p >= edge_tab[ax][n-1]) return 0;
      for (int k = 0; k < n; k++) begin
         if (p <= edge_tab[ax][k+1]) begin
            i = k;
            break;
         end
      end
      if (i < 1) i = 1;
      if (i > n - 2) i = n - 2;
      lo = (2 * p < edge_tab[ax][i] + edge_tab[ax][i+1]) ? i - 1 : i;
      num = 2 * p - (edge_tab[ax][lo] + edge_tab[ax][lo+1]);
      span = (edge_tab[ax][lo+1] + edge_tab[ax][lo+2]) - (edge_tab[ax][lo] + edge_tab[ax][lo+1]);
      if (num <= 0) t = 0;
      else if (num >= span) t = 65536;
      else t = (longint'(num) <<< 16) / span;
      return 1;
   endfunction

   function automatic longint unsigned blend(longint unsigned a, longint unsigned b,
                                             longint unsigned t);
      return (a * (65536 - t) + b * t + 32768) >> 16;
   endfunction

   function automatic longint unsigned dens(int i, int j, int k);
      return voxel_dens[(i * MaxDim + j) * MaxDim + k];
   endfunction

   function automatic sample_type predict_query(logic [183:0] d);
      sample_type s;
      int lx, ly, lz;
      longint unsigned tx, ty, tz, c00, c10, c01, c11, e0, e1;
      bit ok;
      s = '0;
      ok = find_cell(0, clamp_count(voxel_regs[0]), longint'($signed(d[115:84])), lx, tx);
      ok = ok && find_cell(1, clamp_count(voxel_regs[1]), longint'($signed(d[147:116])), ly, ty);
      ok = ok && find_cell(2, clamp_count(voxel_regs[2]), longint'($signed(d[179:148])), lz, tz);
      if (!ok) return s;
      c00 = blend(dens(lx, ly, lz), dens(lx+1, ly, lz), tx);
      c10 = blend(dens(lx, ly+1, lz), dens(lx+1, ly+1, lz), tx);
      c01 = blend(dens(lx, ly, lz+1), dens(lx+1, ly, lz+1), tx);
      c11 = blend(dens(lx, ly+1, lz+1), dens(lx+1, ly+1, lz+1), tx);
      e0 = blend(c00, c10, ty);
      e1 = blend(c01, c11, ty);
      s.density = DensBits'(blend(e0, e1, tz));
      s.in_range = 1'b1;
      return s;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
      mismatches++;
   endtask

   initial begin
      mismatches = 0;
      pending_results = 0;
      inside_results = 0;
      foreach (voxel_dens[i]) voxel_dens[i] = '0;
      foreach (edge_tab[a, i]) edge_tab[a][i] = 0;
      foreach (voxel_regs[i]) voxel_regs[i] = 7'd64;
   end

   always @(posedge clock) begin
      sample_type want;
      req_type_type kind;
      int bi;
      if (reset) begin
         foreach (voxel_regs[i]) voxel_regs[i] = 7'd64;
         expected_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_VX: voxel_regs[0] = csr_wdata;
               CSR_VY: voxel_regs[1] = csr_wdata;
               CSR_VZ: voxel_regs[2] = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               report("unexpected transfer", rsp_tdata, 0);
            end else begin
               want = expected_q.pop_front();
               if (rsp_tdata[24] !== want.in_range)
                  report("in_range", rsp_tdata[24], want.in_range);
               if (rsp_tdata[23:0] !== want.density)
                  report("interp_density", rsp_tdata[23:0], want.density);
            end
         end
         if (req_tvalid && req_tready) begin
            kind = req_type_type'(req_tdata[2:0]);
            bi = req_tdata[9:3];
            case (kind)
               REQ_XB, REQ_YB, REQ_ZB:
                  if (bi <= MaxDim) edge_tab[kind][bi] = longint'($signed(req_tdata[41:10]));
               REQ_DENS:
                  voxel_dens[(int'(req_tdata[47:42]) * MaxDim + int'(req_tdata[53:48])) * MaxDim
                             + int'(req_tdata[59:54])] = req_tdata[83:60];
               REQ_QUERY: begin
                  want = predict_query(req_tdata);
                  if (want.in_range) inside_results++;
                  expected_q.push_back(want);
               end
               default: ;
            endcase
         end
      end
      pending_results = expected_q.size();
   end
endmodule

// ===== test/tb_nonuniform_grid_trilinear_interp_top.sv =====
`timescale 1ns / 1ps
module tb_nonuniform_grid_trilinear_interp_top;
   import ngti_pkg::*;

   logic clock, reset;
   logic req_tvalid, req_tready;
   logic [183:0] req_tdata;
   logic rsp_tvalid, rsp_tready;
   logic [31:0] rsp_tdata;
   logic csr_we;
   logic [1:0] csr_index;
   logic [6:0] csr_wdata;
   int mismatches, pending_results, inside_results;

   int send_idle, recv_idle, stall_count;
   bit hold_rsp;
   longint grid_edge[3][MaxDim+1];
   longint pitch[3];
   int used_dims[3];
   int query_count, write_count;

   nonuniform_grid_trilinear_interp_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   nonuniform_grid_trilinear_interp_checker checker_i (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .mismatches(mismatches), .pending_results(pending_results),
      .inside_results(inside_results)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (300) @(negedge clock);
            hold_rsp = 0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         stall_count <= 0;
      end else if (stall_count >= 20000) begin
         $display("Some tests failed");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   function automatic int clamp_count(int r);
      if (r < 3) return 3;
      if (r > MaxDim) return MaxDim;
      return r;
   endfunction

   task automatic send(req_type_type kind, logic [6:0] bidx, logic [31:0] bval,
                       logic [5:0] vx, logic [5:0] vy, logic [5:0] vz, logic [23:0] dv,
                       logic [31:0] qx, logic [31:0] qy, logic [31:0] qz);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'd0, qz, qy, qx, dv, vz, vy, vx, bval, bidx, kind};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (kind == REQ_QUERY) query_count++;
      else write_count++;
      @(negedge clock);
   endtask

   task automatic write_edge(int ax, int idx, longint val);
      send(req_type_type'(ax), 7'(idx), 32'(val), '0, '0, '0, '0, '0, '0, '0);
      if (idx <= MaxDim) grid_edge[ax][idx] = longint'($signed(32'(val)));
   endtask

   task automatic write_voxel(int x, int y, int z, logic [23:0] v);
      send(REQ_DENS, '0, '0, 6'(x), 6'(y), 6'(z), v, '0, '0, '0);
   endtask

   function automatic longint ordered_edge(int ax, int i);
      return -20 * pitch[ax] + i * pitch[ax] + longint'($urandom_range(0, 32'(pitch[ax] / 4)));
   endfunction

   // Keeps each axis search inside voxels 0..4, whose densities are loaded.
   function automatic longint keep_safe(int ax, longint p);
      if (p > grid_edge[ax][4] && p > grid_edge[ax][1] && p < grid_edge[ax][used_dims[ax]-1])
         return grid_edge[ax][4];
      return p;
   endfunction

   function automatic longint pick_coord(int ax);
      longint lo, hi, p;
      int k;
      k = $urandom_range(0, 4);
      case ($urandom_range(9))
         0: p = longint'($signed($urandom()));
         1: p = grid_edge[ax][$urandom_range(0, 5)];
         2: p = (grid_edge[ax][k] + grid_edge[ax][k+1]) / 2;
         default: begin
            lo = grid_edge[ax][0];
            hi = grid_edge[ax][5];
            p = (hi > lo) ? lo + longint'($urandom()) % (hi - lo + 1) : lo;
         end
      endcase
      return keep_safe(ax, p);
   endfunction

   task automatic query(longint x, longint y, longint z);
      send(REQ_QUERY, '0, '0, '0, '0, '0, '0,
           32'(keep_safe(0, x)), 32'(keep_safe(1, y)), 32'(keep_safe(2, z)));
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_results != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic set_dims(int vx, int vy, int vz);
      int vals[3];
      vals = '{vx, vy, vz};
      foreach (vals[i]) begin
         csr_we <= 1'b1;
         csr_index <= 2'(i);
         csr_wdata <= 7'(vals[i]);
         used_dims[i] = clamp_count(vals[i]);
         @(negedge clock);
      end
      csr_index <= 2'd3;
      csr_wdata <= 7'($urandom_range(127));
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic random_item();
      int ax, idx, r;
      r = $urandom_range(99);
      if (r < 55) begin
         query(pick_coord(0), pick_coord(1), pick_coord(2));
      end else if (r < 72) begin
         write_voxel($urandom_range(63), $urandom_range(63), $urandom_range(63),
                     24'($urandom()));
      end else if (r < 94) begin
         ax = $urandom_range(2);
         idx = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(0, 64);
         write_edge(ax, idx, ($urandom_range(9) == 0) ? longint'($signed($urandom()))
                                                      : ordered_edge(ax, idx));
      end else begin
         send(req_type_type'($urandom_range(5, 7)), 7'($urandom()), $urandom(), 6'($urandom()),
              6'($urandom()), 6'($urandom()), 24'($urandom()), $urandom(), $urandom(),
              $urandom());
      end
   endtask

   initial begin
      int dims[9][3];
      dims = '{'{64, 64, 64}, '{3, 3, 3}, '{0, 127, 5}, '{4, 5, 6}, '{64, 3, 64},
               '{6, 4, 3}, '{127, 0, 64}, '{5, 5, 5}, '{3, 64, 4}};
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      hold_rsp = 0;
      send_idle = 0;
      recv_idle = 0;
      query_count = 0;
      write_count = 0;
      used_dims = '{64, 64, 64};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (pitch[a]) pitch[a] = longint'($urandom_range(65536, 262144));
      for (int a = 0; a < 3; a++)
         for (int i = 0; i <= MaxDim; i++) write_edge(a, i, ordered_edge(a, i));
      for (int x = 0; x < 5; x++)
         for (int y = 0; y < 5; y++)
            for (int z = 0; z < 5; z++) write_voxel(x, y, z, 24'($urandom()));

      // Extremes of the fields, ignored writes and the exact boundaries and centres.
      write_voxel(0, 0, 0, 24'h000000);
      write_voxel(1, 1, 1, 24'hffffff);
      write_voxel(63, 63, 63, 24'hffffff);
      send(req_type_type'(5), 7'h7f, '1, '1, '1, '1, '1, '1, '1, '1);
      send(req_type_type'(6), '0, '0, '0, '0, '0, '0, '0, '0, '0);
      send(req_type_type'(7), 7'h55, 32'h5555_5555, '0, '0, '0, '0, '0, '0, '0);
      write_edge(0, 65, 32'h7fff_ffff);
      write_edge(1, 127, 32'h8000_0000);
      query(-64'sd2147483648, 0, 0);
      query(64'sd2147483647, grid_edge[1][2], grid_edge[2][2]);
      query(grid_edge[0][1], grid_edge[1][2], grid_edge[2][2]);
      query(grid_edge[0][2], grid_edge[1][2], grid_edge[2][2]);
      query((grid_edge[0][1] + grid_edge[0][2]) / 2, (grid_edge[1][2] + grid_edge[1][3]) / 2,
            (grid_edge[2][3] + grid_edge[2][4]) / 2);
      query(grid_edge[0][1] + 1, grid_edge[1][4] - 1, grid_edge[2][2] + 1);
      write_edge(0, 3, grid_edge[0][2]);
      query(grid_edge[0][2], grid_edge[1][2] + 7, grid_edge[2][2] - 7);
      query(grid_edge[0][2] + 1, grid_edge[1][3], grid_edge[2][3]);
      write_edge(0, 3, grid_edge[0][2] - 5);
      query(grid_edge[0][2] + 1, grid_edge[1][3], grid_edge[2][3]);
      write_edge(0, 3, ordered_edge(0, 3));
      write_edge(2, 64, 32'h7fff_ffff);
      query(pick_coord(0), pick_coord(1), 64'sd2147483647);
      write_edge(2, 64, ordered_edge(2, 64));
      drain();

      for (int mode = 0; mode < 3; mode++) begin
         send_idle = (mode == 0) ? 24 : (mode == 1) ? 76 : 0;
         recv_idle = (mode == 0) ? 76 : (mode == 1) ? 24 : 0;
         for (int c = 0; c < 3; c++) begin
            set_dims(dims[mode*3+c][0], dims[mode*3+c][1], dims[mode*3+c][2]);
            for (int n = 0; n < 122; n++) begin
               if (mode == 0 && c == 0 && n == 40) hold_rsp = 1;
               if (n == 60) drain();
               random_item();
            end
            drain();
         end
      end

      repeat (400) @(negedge clock);
      $display("Covered %0d queries (%0d inside the grid) and %0d write or ignored transfers",
               query_count, inside_results, write_count);
      $display("over nine axis size settings, clamped ones included, under three stall mixes.");
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule

// ===== files.f =====
hw/rtl/ngti_pkg.sv
hw/rtl/ngti_lerp.sv
hw/rtl/ngti_div.sv
hw/rtl/nonuniform_grid_trilinear_interp_top.sv
test/nonuniform_grid_trilinear_interp_checker.sv
test/tb_nonuniform_grid_trilinear_interp_top.sv
